@@ sv/smwm_pkg.sv @@
package smwm_pkg;

  // storage geometry
  localparam int unsigned SEGMENTS    = 4;
  localparam int unsigned SEG_WORDS   = 1024;
  localparam int unsigned STORE_WORDS = SEGMENTS * SEG_WORDS;
  localparam int unsigned SLOT_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  // register map: start/end pair per segment, four pairs always exist
  localparam int unsigned REG_SEGS  = 4;
  localparam int unsigned NUM_REGS  = 2 * REG_SEGS;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

  localparam int unsigned DATA_W = 16;

  localparam logic [DATA_W-1:0] DATA_RESET  = 16'h0000;
  localparam logic [DATA_W-1:0] MASK_RESET  = 16'hFFFF;
  localparam logic [DATA_W-1:0] START_RESET = 16'hFFFF;
  localparam logic [DATA_W-1:0] END_RESET   = 16'h0000;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_SET_MASK = 2'd2
  } op_e;

  // decoded location of one access
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } loc_t;

  // access entering the store
  typedef struct packed {
    logic              valid;
    op_e               op;
    loc_t              loc;
    logic [DATA_W-1:0] value;
  } req_t;

  // result beat
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] read_data;
    logic              status;
  } res_t;

endpackage

@@ sv/smwm_seg_map.sv @@
module smwm_seg_map import smwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic [1:0]           op_i,
  input  logic [DATA_W-1:0]    addr_i,
  output loc_t                 loc_o
);

  logic [DATA_W-1:0] seg_start_q [REG_SEGS];
  logic [DATA_W-1:0] seg_end_q   [REG_SEGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < REG_SEGS; s++) begin
        seg_start_q[s] <= START_RESET;
        seg_end_q[s]   <= END_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0]) begin
        seg_end_q[cfg_idx_i[REG_IDX_W-1:1]] <= cfg_data_i;
      end else begin
        seg_start_q[cfg_idx_i[REG_IDX_W-1:1]] <= cfg_data_i;
      end
    end
  end

  logic [SEGMENTS-1:0] in_range;
  logic [SEGMENTS-1:0] idx_ok;
  logic [DATA_W-1:0]   offs [SEGMENTS];
  logic [SLOT_W-1:0]   slot [SEGMENTS];
  logic                op_ok;

  always_comb begin
    for (int s = 0; s < SEGMENTS; s++) begin
      in_range[s] = (addr_i >= seg_start_q[s]) && (addr_i <= seg_end_q[s]);
      offs[s]     = addr_i - seg_start_q[s];
      idx_ok[s]   = {1'b0, offs[s][DATA_W-1:1]} < DATA_W'(SEG_WORDS);
      slot[s]     = SLOT_W'(32'(s) * 32'(SEG_WORDS) + 32'(offs[s][DATA_W-1:1]));
    end
  end

  assign op_ok = (op_i == OP_READ) || (op_i == OP_WRITE) || (op_i == OP_SET_MASK);

  // lowest segment that holds the address wins, even if its index overflows
  always_comb begin
    logic found;
    found      = 1'b0;
    loc_o.hit  = 1'b0;
    loc_o.slot = '0;
    for (int s = 0; s < SEGMENTS; s++) begin
      if (!found && in_range[s]) begin
        found      = 1'b1;
        loc_o.hit  = idx_ok[s] && op_ok;
        loc_o.slot = slot[s];
      end
    end
  end

endmodule

@@ sv/smwm_store.sv @@
module smwm_store import smwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  output logic busy_o,
  output res_t res_o
);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] clr_cnt_q;
  logic              clearing;

  logic [DATA_W-1:0] data_mem [STORE_WORDS];
  logic [DATA_W-1:0] mask_mem [STORE_WORDS];
  logic [DATA_W-1:0] data_rd_q, mask_rd_q;

  logic              s2_valid_q, s2_hit_q;
  op_e               s2_op_q;
  logic [SLOT_W-1:0] s2_slot_q;
  logic [DATA_W-1:0] s2_val_q;

  logic              fwd_data_q, fwd_data_d, fwd_mask_q, fwd_mask_d;
  logic [DATA_W-1:0] fwd_data_val_q, fwd_mask_val_q;

  logic [DATA_W-1:0] cur_data, cur_mask, new_data;
  logic              wr_data, wr_mask, same_slot;
  logic              data_we, mask_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [DATA_W-1:0] data_wd, mask_wd;

  logic              res_valid_q;
  logic [DATA_W-1:0] res_data_q;
  logic              res_status_q;

  assign clearing = (state_q == ST_CLEAR);
  assign busy_o   = clearing;

  // clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == SLOT_W'(STORE_WORDS - 1)) begin
            state_q <= ST_RUN;
          end
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
        ST_RUN: begin
          state_q <= ST_RUN;
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  // newest value wins over the stale read
  assign cur_data = fwd_data_q ? fwd_data_val_q : data_rd_q;
  assign cur_mask = fwd_mask_q ? fwd_mask_val_q : mask_rd_q;
  assign new_data = (cur_data & ~cur_mask) | (s2_val_q & cur_mask);

  assign wr_data = s2_valid_q && s2_hit_q && (s2_op_q == OP_WRITE);
  assign wr_mask = s2_valid_q && s2_hit_q && (s2_op_q == OP_SET_MASK);

  assign same_slot  = req_i.valid && req_i.loc.hit && (req_i.loc.slot == s2_slot_q);
  assign fwd_data_d = wr_data && same_slot;
  assign fwd_mask_d = wr_mask && same_slot;

  assign data_we = clearing || wr_data;
  assign mask_we = clearing || wr_mask;
  assign wr_addr = clearing ? clr_cnt_q : s2_slot_q;
  assign data_wd = clearing ? DATA_RESET : new_data;
  assign mask_wd = clearing ? MASK_RESET : s2_val_q;

  always_ff @(posedge clk_i) begin
    data_rd_q <= data_mem[req_i.loc.slot];
    mask_rd_q <= mask_mem[req_i.loc.slot];
    if (data_we) begin
      data_mem[wr_addr] <= data_wd;
    end
    if (mask_we) begin
      mask_mem[wr_addr] <= mask_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_data_q  <= 1'b0;
      fwd_mask_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= req_i.valid;
      fwd_data_q  <= fwd_data_d;
      fwd_mask_q  <= fwd_mask_d;
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_hit_q       <= req_i.loc.hit;
    s2_op_q        <= req_i.op;
    s2_slot_q      <= req_i.loc.slot;
    s2_val_q       <= req_i.value;
    fwd_data_val_q <= new_data;
    fwd_mask_val_q <= s2_val_q;
    res_data_q     <= (s2_hit_q && (s2_op_q == OP_READ)) ? cur_data : DATA_RESET;
    res_status_q   <= !s2_hit_q;
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.read_data = res_data_q;
  assign res_o.status    = res_status_q;

  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s2_valid_q && !req_i.valid)
    else $error("item in pipeline during clear sweep");

  a_fwd_data_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_data_q |-> $past(wr_data))
    else $error("data forward without a write");

  a_fwd_mask_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_mask_q |-> $past(wr_mask) && !fwd_data_q)
    else $error("mask forward without a mask write");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> res_valid_q)
    else $error("access lost its result");

endmodule

@@ sv/segmented_memory_with_write_mask_top.sv @@
// channel  | signals                              | handshake
// ---------+--------------------------------------+---------------------------------
// request  | opcode_i, address_i, data_value_i    | taken when start_i && !busy_o
// result   | read_data_o, status_o                | valid_o high for one cycle
// config   | cfg_we_i, cfg_idx_i, cfg_data_i      | written when cfg_we_i is high
//
// one access per cycle sustained while busy_o is low; each result beat passes the input register,
// the registered memory read and the result register
// after reset a clear sweep writes all 4096 entries, busy_o high
// config writes are taken during the sweep as well
// the receiver cannot stall, every result beat shows for exactly one cycle
module segmented_memory_with_write_mask_top import smwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           opcode_i,
  input  logic [DATA_W-1:0]    address_i,
  input  logic [DATA_W-1:0]    data_value_i,
  output logic                 valid_o,
  output logic [DATA_W-1:0]    read_data_o,
  output logic                 status_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // input stage
  logic              s1_valid_q;
  logic [1:0]        s1_op_q;
  logic [DATA_W-1:0] s1_addr_q, s1_val_q;
  logic              accept;

  loc_t loc;
  req_t req;
  res_t res;
  logic busy;

  assign accept = start_i && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= opcode_i;
      s1_addr_q <= address_i;
      s1_val_q  <= data_value_i;
    end
  end

  // segment registers and address decode
  smwm_seg_map u_seg_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (s1_op_q),
    .addr_i     (s1_addr_q),
    .loc_o      (loc)
  );

  // opcode 3 never hits, so its enum value is never looked at
  assign req.valid = s1_valid_q;
  assign req.op    = op_e'(s1_op_q);
  assign req.loc   = loc;
  assign req.value = s1_val_q;

  // data and mask memories with read-modify-write and forwarding
  smwm_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (busy),
    .res_o  (res)
  );

  assign busy_o      = busy;
  assign valid_o     = res.valid;
  assign read_data_o = res.read_data;
  assign status_o    = res.status;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> ##1 valid_o)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(s1_valid_q, 2))
    else $error("result beat without an access");

  a_invalid_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> read_data_o == DATA_RESET)
    else $error("invalid access returned data");

endmodule
